// ===== hdl/bfha_pkg.sv =====
package bfha_pkg;

    localparam int HOLE_SLOTS_DEF   = 256;
    localparam int BLOCK_SLOTS_DEF  = 512;
    localparam int INITIAL_SIZE_DEF = 32'h10000;
    localparam int GROW_STEP_DEF    = 32'h100000;
    localparam int HEADER_BYTES_DEF = 12;
    localparam int FOOTER_BYTES_DEF = 8;

    localparam logic [24:0] ADDR_SPAN = 25'h1000000;

    localparam logic [2:0] ST_OK   = 3'd0;
    localparam logic [2:0] ST_OOM  = 3'd1;
    localparam logic [2:0] ST_BAD  = 3'd2;
    localparam logic [2:0] ST_NULL = 3'd3;
    localparam logic [2:0] ST_FULL = 3'd4;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef struct packed {
        logic        operation;
        logic [23:0] request_size;
        logic [23:0] block_address;
    } t_req;

    typedef struct packed {
        logic [23:0] result_address;
        logic [2:0]  status;
        logic [24:0] total_bytes;
        logic [24:0] free_bytes;
    } t_rsp;

    // one block table entry
    typedef struct packed {
        logic [23:0] off;
        logic [23:0] size;
        logic        hole;
    } t_blk;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_SCAN,
        S_FIT,
        S_GROW_CALC,
        S_GROW,
        S_SPLIT,
        S_FREE_CHK,
        S_COPY,
        S_WR_A,
        S_WR_B,
        S_DONE
    } t_state;

endpackage

// ===== hdl/best_fit_heap_allocator.sv =====
// Best-fit heap allocator with boundary tags and coalescing.
// Request channel (i_valid/o_ready, i_req): operation 0 allocates request_size
// bytes, 1 frees the block whose payload starts at block_address.
// Response channel (o_valid/i_ready, o_rsp): one response per request with the
// granted address, a status code and the heap extent and free byte count.
// i_cfg_we/i_cfg_data write the heap growth limit; write it only when idle.
// One request is in flight at a time; o_ready is high only while idle.
// Steps: a linear scan of the block table (one entry a cycle), then, if a
// block is split or merged, a copy pass that moves the table tail by one or
// two places (one entry a cycle); growth, when no hole fits, runs in steps.
// A null free skips the scan. The block table sits in a single-port-write,
// single-port-read RAM and that port sets the pace of the scan and copy.
// Reset: synchronous, active low. After release the initial hole is first
// written into the table, then o_ready rises.
// A response waits in the output register while the receiver stalls; the
// next request is accepted meanwhile but its response waits behind it.
module best_fit_heap_allocator #(
    parameter int HOLE_SLOTS   = bfha_pkg::HOLE_SLOTS_DEF,
    parameter int BLOCK_SLOTS  = bfha_pkg::BLOCK_SLOTS_DEF,
    parameter int INITIAL_SIZE = bfha_pkg::INITIAL_SIZE_DEF,
    parameter int GROW_STEP    = bfha_pkg::GROW_STEP_DEF,
    parameter int HEADER_BYTES = bfha_pkg::HEADER_BYTES_DEF,
    parameter int FOOTER_BYTES = bfha_pkg::FOOTER_BYTES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  bfha_pkg::t_req i_req,
    output logic           o_valid,
    input  logic           i_ready,
    output bfha_pkg::t_rsp o_rsp,
    input  logic           i_cfg_we,
    input  logic [24:0]    i_cfg_data
);
    import bfha_pkg::*;

    localparam int IW  = $clog2(BLOCK_SLOTS);
    localparam int CW  = $clog2(BLOCK_SLOTS + 1);
    localparam int HW  = $clog2(HOLE_SLOTS + 1);
    localparam int TAG = HEADER_BYTES + FOOTER_BYTES;
    localparam logic [23:0] TAG24  = 24'(TAG);
    localparam logic [23:0] HDR24  = 24'(HEADER_BYTES);
    localparam logic [24:0] STEP25 = 25'(GROW_STEP);

    // block table RAM
    t_blk          r_mem [BLOCK_SLOTS];
    t_blk          r_rdata;
    logic          mem_we;
    logic [IW-1:0] mem_wa;
    logic [IW-1:0] mem_ra;
    t_blk          mem_wd;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rdata <= r_mem[mem_ra];
    end

    t_state        r_state, n_state;
    logic [24:0]   r_limit;
    logic          r_op, n_op;
    logic [23:0]   r_req, n_req;
    logic [23:0]   r_target, n_target;
    logic [CW-1:0] r_count, n_count;
    logic [HW-1:0] r_holes, n_holes;
    logic [24:0]   r_heap_end, n_heap_end;
    logic [24:0]   r_free, n_free;
    // scan
    logic [CW-1:0] r_idx, n_idx;
    logic          r_rd_v, n_rd_v;
    logic [CW-1:0] r_rd_idx, n_rd_idx;
    logic          r_found, n_found;
    logic [CW-1:0] r_bi, n_bi;
    t_blk          r_best, n_best;
    t_blk          r_last, n_last;
    t_blk          r_prev, n_prev;
    t_blk          r_left, n_left;
    t_blk          r_right, n_right;
    logic          r_has_left, n_has_left;
    logic          r_has_right, n_has_right;
    logic [24:0]   r_grow, n_grow;
    // copy engine
    logic [CW-1:0] r_cp_src, n_cp_src;
    logic [CW-1:0] r_cp_left, n_cp_left;
    logic          r_cp_up, n_cp_up;
    logic [1:0]    r_cp_d, n_cp_d;
    logic          r_cp_v, n_cp_v;
    logic [CW-1:0] r_cp_pidx, n_cp_pidx;
    // pending entry writes
    logic          r_wa_v, n_wa_v;
    logic [CW-1:0] r_wa_idx, n_wa_idx;
    t_blk          r_wa_dat, n_wa_dat;
    logic          r_wb_v, n_wb_v;
    logic [CW-1:0] r_wb_idx, n_wb_idx;
    t_blk          r_wb_dat, n_wb_dat;
    // response
    logic [23:0]   r_addr, n_addr;
    logic [2:0]    r_status, n_status;
    logic          r_out_v, n_out_v;
    t_rsp          r_rsp, n_rsp;

    logic [24:0]   lim;
    logic [24:0]   room;
    logic [23:0]   rem;
    logic [CW-1:0] cp_dst;
    logic          lh, rh;
    t_blk          grown;

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_v;
    assign o_rsp   = r_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_INIT;
            r_limit    <= ADDR_SPAN;
            r_count    <= CW'(1);
            r_holes    <= HW'(1);
            r_heap_end <= 25'(INITIAL_SIZE);
            r_free     <= 25'(INITIAL_SIZE - TAG);
            r_out_v    <= 1'b0;
            r_rd_v     <= 1'b0;
            r_cp_v     <= 1'b0;
        end else begin
            r_state    <= n_state;
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
            r_count    <= n_count;
            r_holes    <= n_holes;
            r_heap_end <= n_heap_end;
            r_free     <= n_free;
            r_out_v    <= n_out_v;
            r_rd_v     <= n_rd_v;
            r_cp_v     <= n_cp_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_req       <= n_req;
        r_target    <= n_target;
        r_idx       <= n_idx;
        r_rd_idx    <= n_rd_idx;
        r_found     <= n_found;
        r_bi        <= n_bi;
        r_best      <= n_best;
        r_last      <= n_last;
        r_prev      <= n_prev;
        r_left      <= n_left;
        r_right     <= n_right;
        r_has_left  <= n_has_left;
        r_has_right <= n_has_right;
        r_grow      <= n_grow;
        r_cp_src    <= n_cp_src;
        r_cp_left   <= n_cp_left;
        r_cp_up     <= n_cp_up;
        r_cp_d      <= n_cp_d;
        r_cp_pidx   <= n_cp_pidx;
        r_wa_v      <= n_wa_v;
        r_wa_idx    <= n_wa_idx;
        r_wa_dat    <= n_wa_dat;
        r_wb_v      <= n_wb_v;
        r_wb_idx    <= n_wb_idx;
        r_wb_dat    <= n_wb_dat;
        r_addr      <= n_addr;
        r_status    <= n_status;
        r_rsp       <= n_rsp;
    end

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_req       = r_req;
        n_target    = r_target;
        n_count     = r_count;
        n_holes     = r_holes;
        n_heap_end  = r_heap_end;
        n_free      = r_free;
        n_idx       = r_idx;
        n_rd_v      = 1'b0;
        n_rd_idx    = r_rd_idx;
        n_found     = r_found;
        n_bi        = r_bi;
        n_best      = r_best;
        n_last      = r_last;
        n_prev      = r_prev;
        n_left      = r_left;
        n_right     = r_right;
        n_has_left  = r_has_left;
        n_has_right = r_has_right;
        n_grow      = r_grow;
        n_cp_src    = r_cp_src;
        n_cp_left   = r_cp_left;
        n_cp_up     = r_cp_up;
        n_cp_d      = r_cp_d;
        n_cp_v      = 1'b0;
        n_cp_pidx   = r_cp_pidx;
        n_wa_v      = r_wa_v;
        n_wa_idx    = r_wa_idx;
        n_wa_dat    = r_wa_dat;
        n_wb_v      = r_wb_v;
        n_wb_idx    = r_wb_idx;
        n_wb_dat    = r_wb_dat;
        n_addr      = r_addr;
        n_status    = r_status;
        n_rsp       = r_rsp;
        n_out_v     = r_out_v && !i_ready;
        mem_we      = 1'b0;
        mem_wa      = '0;
        mem_wd      = '0;
        mem_ra      = '0;

        lim    = (r_limit > ADDR_SPAN) ? ADDR_SPAN : r_limit;
        room   = lim - r_heap_end;
        rem    = r_best.size - r_req;
        cp_dst = r_cp_up ? (r_cp_pidx + CW'(1)) : (r_cp_pidx - CW'(r_cp_d));
        lh     = r_has_left && r_left.hole;
        rh     = r_has_right && r_right.hole;
        grown  = '{off: r_last.off, size: r_last.size + r_grow[23:0], hole: 1'b1};

        unique case (r_state)
            S_INIT: begin
                mem_we  = 1'b1;
                mem_wa  = '0;
                mem_wd  = '{off: 24'd0, size: 24'(INITIAL_SIZE - TAG), hole: 1'b1};
                n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_op        = i_req.operation;
                    n_req       = i_req.request_size;
                    n_target    = i_req.block_address - HDR24;
                    n_idx       = '0;
                    n_found     = 1'b0;
                    n_has_left  = 1'b0;
                    n_has_right = 1'b0;
                    n_wa_v      = 1'b0;
                    n_wb_v      = 1'b0;
                    n_addr      = '0;
                    n_status    = ST_OK;
                    n_state     = S_SCAN;
                    if (i_req.operation == OP_FREE) begin
                        if (i_req.block_address == 24'd0) begin
                            n_status = ST_NULL;
                            n_state  = S_DONE;
                        end else if (i_req.block_address < HDR24) begin
                            n_status = ST_BAD;
                            n_state  = S_DONE;
                        end
                    end
                end
            end
            S_SCAN: begin
                if (r_idx != r_count) begin
                    mem_ra   = r_idx[IW-1:0];
                    n_idx    = r_idx + CW'(1);
                    n_rd_v   = 1'b1;
                    n_rd_idx = r_idx;
                end
                if (r_rd_v) begin
                    if (r_op == OP_ALLOC) begin
                        // strict less keeps the lowest address on a size tie
                        if (r_rdata.hole && r_rdata.size >= r_req &&
                            (!r_found || r_rdata.size < r_best.size)) begin
                            n_found = 1'b1;
                            n_best  = r_rdata;
                            n_bi    = r_rd_idx;
                        end
                        if (r_rd_idx == r_count - CW'(1)) begin
                            n_last = r_rdata;
                        end
                    end else begin
                        n_prev = r_rdata;
                        if (!r_found && r_rdata.off == r_target) begin
                            n_found    = 1'b1;
                            n_bi       = r_rd_idx;
                            n_best     = r_rdata;
                            n_left     = r_prev;
                            n_has_left = (r_rd_idx != '0);
                        end else if (r_found && !r_has_right) begin
                            n_right     = r_rdata;
                            n_has_right = 1'b1;
                        end
                    end
                end
                if (r_idx == r_count && !r_rd_v) begin
                    n_state = (r_op == OP_FREE) ? S_FREE_CHK : S_FIT;
                end
            end
            S_FIT: begin
                n_state = r_found ? S_SPLIT : S_GROW_CALC;
            end
            S_GROW_CALC: begin
                if (r_heap_end >= lim) begin
                    n_status = ST_OOM;
                    n_state  = S_DONE;
                end else begin
                    n_grow  = (room > STEP25) ? STEP25 : room;
                    n_state = S_GROW;
                end
            end
            S_GROW: begin
                if (r_last.hole) begin
                    // extend the trailing hole
                    mem_we     = 1'b1;
                    mem_wa     = IW'(r_count - CW'(1));
                    mem_wd     = grown;
                    n_last     = grown;
                    n_heap_end = r_heap_end + r_grow;
                    n_free     = r_free + r_grow;
                    n_bi       = r_count - CW'(1);
                    n_best     = grown;
                    n_found    = (grown.size >= r_req);
                    n_state    = (grown.size >= r_req) ? S_SPLIT : S_GROW_CALC;
                end else if (r_grow < 25'(TAG)) begin
                    n_status = ST_OOM;
                    n_state  = S_DONE;
                end else if (r_count >= CW'(BLOCK_SLOTS) || r_holes >= HW'(HOLE_SLOTS)) begin
                    n_status = ST_FULL;
                    n_state  = S_DONE;
                end else begin
                    // append a new trailing hole
                    mem_we     = 1'b1;
                    mem_wa     = r_count[IW-1:0];
                    mem_wd     = '{off: r_heap_end[23:0], size: r_grow[23:0] - TAG24,
                                   hole: 1'b1};
                    n_last     = mem_wd;
                    n_best     = mem_wd;
                    n_bi       = r_count;
                    n_count    = r_count + CW'(1);
                    n_holes    = r_holes + HW'(1);
                    n_heap_end = r_heap_end + r_grow;
                    n_free     = r_free + r_grow - 25'(TAG);
                    n_found    = (mem_wd.size >= r_req);
                    n_state    = (mem_wd.size >= r_req) ? S_SPLIT : S_GROW_CALC;
                end
            end
            S_SPLIT: begin
                if (rem <= TAG24) begin
                    // hand out the whole hole
                    n_wa_v   = 1'b1;
                    n_wa_idx = r_bi;
                    n_wa_dat = '{off: r_best.off, size: r_best.size, hole: 1'b0};
                    n_holes  = r_holes - HW'(1);
                    n_free   = r_free - {1'b0, r_best.size};
                    n_addr   = r_best.off + HDR24;
                    n_state  = S_WR_A;
                end else if (r_count >= CW'(BLOCK_SLOTS)) begin
                    n_status = ST_FULL;
                    n_state  = S_DONE;
                end else begin
                    n_wa_v    = 1'b1;
                    n_wa_idx  = r_bi;
                    n_wa_dat  = '{off: r_best.off, size: r_req, hole: 1'b0};
                    n_wb_v    = 1'b1;
                    n_wb_idx  = r_bi + CW'(1);
                    n_wb_dat  = '{off: r_best.off + TAG24 + r_req, size: rem - TAG24,
                                  hole: 1'b1};
                    n_count   = r_count + CW'(1);
                    n_free    = r_free - {1'b0, r_req} - 25'(TAG);
                    n_addr    = r_best.off + HDR24;
                    n_cp_up   = 1'b1;
                    n_cp_d    = 2'd1;
                    n_cp_src  = r_count - CW'(1);
                    n_cp_left = r_count - CW'(1) - r_bi;
                    n_state   = S_COPY;
                end
            end
            S_FREE_CHK: begin
                n_cp_up = 1'b0;
                if (!r_found || r_best.hole) begin
                    n_status = ST_BAD;
                    n_state  = S_DONE;
                end else if (!lh && !rh && r_holes >= HW'(HOLE_SLOTS)) begin
                    n_status = ST_FULL;
                    n_state  = S_DONE;
                end else if (lh && rh) begin
                    n_wa_v    = 1'b1;
                    n_wa_idx  = r_bi - CW'(1);
                    n_wa_dat  = '{off: r_left.off,
                                  size: r_left.size + r_best.size + r_right.size
                                        + TAG24 + TAG24,
                                  hole: 1'b1};
                    n_cp_d    = 2'd2;
                    n_cp_src  = r_bi + CW'(2);
                    n_cp_left = r_count - r_bi - CW'(2);
                    n_count   = r_count - CW'(2);
                    n_holes   = r_holes - HW'(1);
                    n_free    = r_free + {1'b0, r_best.size} + 25'(2 * TAG);
                    n_state   = S_COPY;
                end else if (lh) begin
                    n_wa_v    = 1'b1;
                    n_wa_idx  = r_bi - CW'(1);
                    n_wa_dat  = '{off: r_left.off, size: r_left.size + r_best.size + TAG24,
                                  hole: 1'b1};
                    n_cp_d    = 2'd1;
                    n_cp_src  = r_bi + CW'(1);
                    n_cp_left = r_count - r_bi - CW'(1);
                    n_count   = r_count - CW'(1);
                    n_free    = r_free + {1'b0, r_best.size} + 25'(TAG);
                    n_state   = S_COPY;
                end else if (rh) begin
                    n_wa_v    = 1'b1;
                    n_wa_idx  = r_bi;
                    n_wa_dat  = '{off: r_best.off, size: r_best.size + r_right.size + TAG24,
                                  hole: 1'b1};
                    n_cp_d    = 2'd1;
                    n_cp_src  = r_bi + CW'(2);
                    n_cp_left = r_count - r_bi - CW'(2);
                    n_count   = r_count - CW'(1);
                    n_free    = r_free + {1'b0, r_best.size} + 25'(TAG);
                    n_state   = S_COPY;
                end else begin
                    n_wa_v   = 1'b1;
                    n_wa_idx = r_bi;
                    n_wa_dat = '{off: r_best.off, size: r_best.size, hole: 1'b1};
                    n_holes  = r_holes + HW'(1);
                    n_free   = r_free + {1'b0, r_best.size};
                    n_state  = S_WR_A;
                end
            end
            S_COPY: begin
                // read one entry, write it in the next cycle at its new place
                if (r_cp_v) begin
                    mem_we = 1'b1;
                    mem_wa = cp_dst[IW-1:0];
                    mem_wd = r_rdata;
                end
                if (r_cp_left != '0) begin
                    mem_ra    = r_cp_src[IW-1:0];
                    n_cp_v    = 1'b1;
                    n_cp_pidx = r_cp_src;
                    n_cp_src  = r_cp_up ? (r_cp_src - CW'(1)) : (r_cp_src + CW'(1));
                    n_cp_left = r_cp_left - CW'(1);
                end else if (!r_cp_v) begin
                    n_state = S_WR_A;
                end
            end
            S_WR_A: begin
                if (r_wa_v) begin
                    mem_we = 1'b1;
                    mem_wa = r_wa_idx[IW-1:0];
                    mem_wd = r_wa_dat;
                end
                n_state = S_WR_B;
            end
            S_WR_B: begin
                if (r_wb_v) begin
                    mem_we = 1'b1;
                    mem_wa = r_wb_idx[IW-1:0];
                    mem_wd = r_wb_dat;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_v || i_ready) begin
                    n_out_v = 1'b1;
                    n_rsp   = '{result_address: r_addr, status: r_status,
                                total_bytes: r_heap_end, free_bytes: r_free};
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != '0 && r_count <= CW'(BLOCK_SLOTS))
        else $error("block count out of range");
    a_holes_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_holes <= HW'(HOLE_SLOTS) && {1'b0, r_holes} <= (HW + 1)'(r_count))
        else $error("hole count exceeds limits");
    a_free_le_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_rsp.free_bytes <= o_rsp.total_bytes)
        else $error("free bytes above heap extent");
    a_fail_no_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rsp.status != ST_OK) |-> o_rsp.result_address == 24'd0)
        else $error("address on failed transaction");
`endif

endmodule
